/* sv/complex_fir_edge_replicate_defines.svh */
// Assertion macros for the complex FIR with edge replication.
`ifndef COMPLEX_FIR_EDGE_REPLICATE_DEFINES_SVH
`define COMPLEX_FIR_EDGE_REPLICATE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define CFE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define CFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cfe_pkg.sv */
// Shared types and constants for the complex FIR with edge replication.
package cfe_pkg;

    // Command codes of an input item
    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Fixed width of the tap index field
    localparam int TAP_IDX_W = 5;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_PUSH
    } t_state;

    // Per-cycle control broadcast to every cell of the row
    typedef struct packed {
        logic push;  // shift samples one cell toward index 0
        logic fill;  // load every cell with the same sample
    } t_cell_ctl;

endpackage

/* sv/cfe_if.sv */
// Stream interfaces for input items and result items.
interface cfe_in_if import cfe_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [TAP_IDX_W-1:0]          tap_index;
    logic signed [COEF_BITS-1:0]   coef_re;
    logic signed [COEF_BITS-1:0]   coef_im;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic                          block_end;

    modport source (
        output valid, cmd, tap_index, coef_re, coef_im, sample_re, sample_im, block_end,
        input  ready
    );
    modport sink (
        input  valid, cmd, tap_index, coef_re, coef_im, sample_re, sample_im, block_end,
        output ready
    );
endinterface

interface cfe_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_re;
    logic signed [SAMPLE_BITS-1:0] out_im;
    logic                          out_last;

    modport source (output valid, out_re, out_im, out_last, input ready);
    modport sink   (input valid, out_re, out_im, out_last, output ready);
endinterface

/* sv/complex_fir_edge_replicate.sv */
// Complex FIR with edge replication: a coefficient or plain sample leaves the input ready;
// each output takes one push, then a wait while the partial sum ripples through the row
// of cells and is rounded, held further while the output register is still full.
// A block-end sample occupies the block until its replicated tail has been pushed through.
// Reset (synchronous, active low) closes any open block and empties the output;
// taps hold no reset value and must be written before use.
`include "complex_fir_edge_replicate_defines.svh"

module complex_fir_edge_replicate import cfe_pkg::*; #(
    parameter int TAPS        = 31,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    cfe_in_if.sink     i_in,
    cfe_out_if.source  o_out
);

    localparam int LEAD  = (TAPS - 1) / 2;
    localparam int LAG   = TAPS - 1 - LEAD;
    localparam int LAG_W = $clog2(LAG + 1);
    localparam int CNT_W = $clog2(TAPS + 2);
    localparam int ACC_W = SAMPLE_BITS + COEF_BITS + $clog2(TAPS) + 1;

    localparam logic [LAG_W-1:0]       LAG_V     = LAG_W'(LAG);
    localparam logic [CNT_W-1:0]       CALC_LAST = CNT_W'(TAPS + 1);
    localparam logic signed [ACC_W-1:0] RND_C    = ACC_W'(1) <<< (COEF_BITS - 2);
    localparam logic signed [ACC_W-1:0] SAT_HI   =
        (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ~SAT_HI;

    // Round half up, drop the fraction, clip to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] v;
        v = (acc + RND_C) >>> (COEF_BITS - 1);
        if (v > SAT_HI) begin
            return SAT_HI[SAMPLE_BITS-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    t_state                        r_state, n_state;
    logic [LAG_W-1:0]              r_lead, n_lead;
    logic                          r_in_block, n_in_block;
    logic [LAG_W-1:0]              r_tail, n_tail;
    logic                          r_end, n_end;
    logic                          r_last_pend, n_last_pend;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic signed [SAMPLE_BITS-1:0] r_hold_re, n_hold_re, r_hold_im, n_hold_im;
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_re, n_out_re, r_out_im, n_out_im;
    logic                          r_out_last, n_out_last;

    logic                          s_in_ready, s_in_xfer, s_smp_xfer, s_coef_xfer;
    logic                          s_slot_free, s_calc_done, s_do_push, s_fill;
    logic                          s_fire, s_close;
    logic [LAG_W-1:0]              s_lead_cur, s_lead_inc;
    logic signed [SAMPLE_BITS-1:0] s_push_re, s_push_im;
    t_cell_ctl                     s_ctl;

    logic signed [SAMPLE_BITS-1:0] w_smp_re [TAPS];
    logic signed [SAMPLE_BITS-1:0] w_smp_im [TAPS];
    logic signed [ACC_W-1:0]       w_acc_re [TAPS];
    logic signed [ACC_W-1:0]       w_acc_im [TAPS];

    // Handshake and sequencing conditions
    always_comb begin
        s_in_ready  = (r_state == S_IDLE);
        s_in_xfer   = i_in.valid && s_in_ready;
        s_smp_xfer  = s_in_xfer && (i_in.cmd == CMD_SAMPLE);
        s_coef_xfer = s_in_xfer && (i_in.cmd == CMD_COEF);
        s_slot_free = !r_out_valid || o_out.ready;
        s_calc_done = (r_state == S_CALC) && (r_cnt == CALC_LAST) && s_slot_free;
        s_do_push   = s_smp_xfer || (r_state == S_PUSH);
        s_fill      = s_smp_xfer && !r_in_block;
        s_lead_cur  = r_in_block ? r_lead : '0;
        s_fire      = (s_lead_cur == LAG_V);
        s_lead_inc  = s_fire ? LAG_V : s_lead_cur + LAG_W'(1);
        s_close     = (s_calc_done && (r_tail == '0) && r_end) ||
                      ((r_state == S_PUSH) && !s_fire && (r_tail == LAG_W'(1)));
        s_push_re   = (r_state == S_IDLE) ? i_in.sample_re : r_hold_re;
        s_push_im   = (r_state == S_IDLE) ? i_in.sample_im : r_hold_im;
        s_ctl.push  = s_do_push && !s_fill;
        s_ctl.fill  = s_fill;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_smp_xfer) begin
                    if (s_fire) begin
                        n_state = S_CALC;
                    end else if (i_in.block_end) begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (s_fire) begin
                    n_state = S_CALC;
                end else if (r_tail == LAG_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_CALC: begin
                if (s_calc_done) begin
                    n_state = (r_tail != '0) ? S_PUSH : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Next values of block bookkeeping and the output register
    always_comb begin
        n_lead      = r_lead;
        n_in_block  = r_in_block;
        n_tail      = r_tail;
        n_end       = r_end;
        n_last_pend = r_last_pend;
        n_hold_re   = r_hold_re;
        n_hold_im   = r_hold_im;
        n_cnt       = (r_cnt == CALC_LAST) ? r_cnt : r_cnt + CNT_W'(1);
        n_out_valid = r_out_valid;
        n_out_re    = r_out_re;
        n_out_im    = r_out_im;
        n_out_last  = r_out_last;

        if (s_do_push) begin
            n_cnt  = '0;
            n_lead = s_lead_inc;
        end
        if (s_smp_xfer) begin
            n_in_block  = 1'b1;
            n_hold_re   = i_in.sample_re;
            n_hold_im   = i_in.sample_im;
            n_end       = i_in.block_end;
            n_tail      = i_in.block_end ? LAG_V : '0;
            n_last_pend = 1'b0;
        end
        if (r_state == S_PUSH) begin
            n_tail      = r_tail - LAG_W'(1);
            n_last_pend = (r_tail == LAG_W'(1));
        end
        if (s_close) begin
            n_lead     = '0;
            n_in_block = 1'b0;
        end

        // Output register: load a finished sum, or drop after a transfer
        if (s_calc_done) begin
            n_out_valid = 1'b1;
            n_out_re    = round_sat(w_acc_re[TAPS-1]);
            n_out_im    = round_sat(w_acc_im[TAPS-1]);
            n_out_last  = r_last_pend;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lead      <= '0;
            r_in_block  <= 1'b0;
            r_tail      <= '0;
            r_end       <= 1'b0;
            r_last_pend <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lead      <= n_lead;
            r_in_block  <= n_in_block;
            r_tail      <= n_tail;
            r_end       <= n_end;
            r_last_pend <= n_last_pend;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hold_re  <= n_hold_re;
        r_hold_im  <= n_hold_im;
        r_out_re   <= n_out_re;
        r_out_im   <= n_out_im;
        r_out_last <= n_out_last;
    end

    // Row of cells: samples move toward cell 0, partial sums toward the last cell
    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] w_nb_re, w_nb_im;
        logic signed [ACC_W-1:0]       w_in_re, w_in_im;
        logic                          w_tap_we;

        if (g == TAPS - 1) begin : g_head
            assign w_nb_re = s_push_re;
            assign w_nb_im = s_push_im;
        end else begin : g_body
            assign w_nb_re = w_smp_re[g+1];
            assign w_nb_im = w_smp_im[g+1];
        end

        if (g == 0) begin : g_first
            assign w_in_re = '0;
            assign w_in_im = '0;
        end else begin : g_chain
            assign w_in_re = w_acc_re[g-1];
            assign w_in_im = w_acc_im[g-1];
        end

        assign w_tap_we = s_coef_xfer && (32'(i_in.tap_index) == 32'(g));

        cfe_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS),
            .ACC_W       (ACC_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (s_ctl),
            .i_nb_re   (w_nb_re),
            .i_nb_im   (w_nb_im),
            .i_fill_re (s_push_re),
            .i_fill_im (s_push_im),
            .i_tap_we  (w_tap_we),
            .i_tap_re  (i_in.coef_re),
            .i_tap_im  (i_in.coef_im),
            .i_acc_re  (w_in_re),
            .i_acc_im  (w_in_im),
            .o_smp_re  (w_smp_re[g]),
            .o_smp_im  (w_smp_im[g]),
            .o_acc_re  (w_acc_re[g]),
            .o_acc_im  (w_acc_im[g])
        );
    end

    // Ports
    assign i_in.ready     = s_in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.out_re   = r_out_re;
    assign o_out.out_im   = r_out_im;
    assign o_out.out_last = r_out_last;

    // Checks
    `CFE_ASSERT_IMP(a_lead_range, 1'b1, r_lead <= LAG_V, "lead count above lag")
    `CFE_ASSERT_IMP(a_idle_no_tail, r_state == S_IDLE, r_tail == '0, "tail left in idle")
    `CFE_ASSERT_NEXT(a_last_closes, s_calc_done && r_last_pend, !r_in_block, "last kept block open")

endmodule

/* sv/cfe_cell.sv */
// One tap cell: delay sample, tap, complex products and partial-sum stage.
module cfe_cell import cfe_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16,
    parameter int ACC_W       = 38
) (
    input  logic                          i_clk,
    input  t_cell_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_nb_re,
    input  logic signed [SAMPLE_BITS-1:0] i_nb_im,
    input  logic signed [SAMPLE_BITS-1:0] i_fill_re,
    input  logic signed [SAMPLE_BITS-1:0] i_fill_im,
    input  logic                          i_tap_we,
    input  logic signed [COEF_BITS-1:0]   i_tap_re,
    input  logic signed [COEF_BITS-1:0]   i_tap_im,
    input  logic signed [ACC_W-1:0]       i_acc_re,
    input  logic signed [ACC_W-1:0]       i_acc_im,
    output logic signed [SAMPLE_BITS-1:0] o_smp_re,
    output logic signed [SAMPLE_BITS-1:0] o_smp_im,
    output logic signed [ACC_W-1:0]       o_acc_re,
    output logic signed [ACC_W-1:0]       o_acc_im
);

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;

    logic signed [SAMPLE_BITS-1:0] r_smp_re, r_smp_im;
    logic signed [COEF_BITS-1:0]   r_tap_re, r_tap_im;
    logic signed [PROD_W-1:0]      r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [ACC_W-1:0]       r_acc_re, r_acc_im;

    // Delay sample: fill for a new block, else shift from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.fill) begin
            r_smp_re <= i_fill_re;
            r_smp_im <= i_fill_im;
        end else if (i_ctl.push) begin
            r_smp_re <= i_nb_re;
            r_smp_im <= i_nb_im;
        end
    end

    // Tap register
    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_tap_re <= i_tap_re;
            r_tap_im <= i_tap_im;
        end
    end

    // Four real products, registered
    always_ff @(posedge i_clk) begin
        r_p_rr <= PROD_W'(r_smp_re) * PROD_W'(r_tap_re);
        r_p_ii <= PROD_W'(r_smp_im) * PROD_W'(r_tap_im);
        r_p_ri <= PROD_W'(r_smp_re) * PROD_W'(r_tap_im);
        r_p_ir <= PROD_W'(r_smp_im) * PROD_W'(r_tap_re);
    end

    // Partial sum handed on to the next cell
    always_ff @(posedge i_clk) begin
        r_acc_re <= i_acc_re + ACC_W'(r_p_rr) - ACC_W'(r_p_ii);
        r_acc_im <= i_acc_im + ACC_W'(r_p_ri) + ACC_W'(r_p_ir);
    end

    assign o_smp_re = r_smp_re;
    assign o_smp_im = r_smp_im;
    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;

endmodule

/* test/tb_complex_fir_edge_replicate.sv */
// Testbench for the complex FIR with edge replication: self-checking, randomized traffic.
`timescale 1ns / 100ps

module tb_complex_fir_edge_replicate;
    import cfe_pkg::*;

    localparam int TAPS        = 31;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int LEAD        = (TAPS - 1) / 2;
    localparam int LAG         = TAPS - 1 - LEAD;
    // Cycles the block may keep working after its last expected output
    localparam int DRAIN_CYCLES = (LAG + 1) * (TAPS + 3) + 50;
    localparam int HOLD_CYCLES  = 800;

    localparam longint OUT_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) <<< (SAMPLE_BITS - 1));

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;

    typedef struct {
        logic                 cmd;
        logic [TAP_IDX_W-1:0] tap_index;
        t_coef                coef_re;
        t_coef                coef_im;
        t_sample              sample_re;
        t_sample              sample_im;
        logic                 block_end;
    } t_fir_item;

    typedef struct {
        t_sample re;
        t_sample im;
        logic    is_last;
    } t_fir_out;

    typedef enum {
        TAPS_EXTREME,
        TAPS_COMPLEX
    } t_tap_kind;

    // Predicts filter outputs from accepted items and compares delivered outputs
    class t_result_board;
        t_coef      tap_re[TAPS];
        t_coef      tap_im[TAPS];
        t_sample    line_re[TAPS];
        t_sample    line_im[TAPS];
        logic [4:0] lead_count;
        bit         in_block;
        t_fir_out   filtered_q[$];
        int         mismatches;
        int         n_seen;

        function new();
            for (int i = 0; i < TAPS; i++) begin
                tap_re[i]  = '0;
                tap_im[i]  = '0;
                line_re[i] = '0;
                line_im[i] = '0;
            end
            lead_count = '0;
            in_block   = 1'b0;
            mismatches = 0;
            n_seen     = 0;
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction

        function t_sample round_saturate(longint acc);
            longint r;
            // round half up, then floor shift
            r = (acc + (longint'(1) <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
            if (r > OUT_MAX)
                r = OUT_MAX;
            else if (r < OUT_MIN)
                r = OUT_MIN;
            return r[SAMPLE_BITS-1:0];
        endfunction

        // Correlation of the window with the taps, no reversal, no conjugation
        function t_fir_out dot_product();
            longint   acc_re;
            longint   acc_im;
            t_fir_out r;
            acc_re = 0;
            acc_im = 0;
            for (int i = 0; i < TAPS; i++) begin
                acc_re += longint'(line_re[i]) * tap_re[i] - longint'(line_im[i]) * tap_im[i];
                acc_im += longint'(line_re[i]) * tap_im[i] + longint'(line_im[i]) * tap_re[i];
            end
            r.re      = round_saturate(acc_re);
            r.im      = round_saturate(acc_im);
            r.is_last = 1'b0;
            return r;
        endfunction

        // One push into the window; an output once LAG block samples precede it
        function void shift_in(t_sample re, t_sample im);
            bit fire;
            fire = (lead_count >= LAG);
            for (int i = 0; i < TAPS - 1; i++) begin
                line_re[i] = line_re[i + 1];
                line_im[i] = line_im[i + 1];
            end
            line_re[TAPS-1] = re;
            line_im[TAPS-1] = im;
            if (lead_count < LAG)
                lead_count++;
            if (fire)
                filtered_q.push_back(dot_product());
        endfunction

        function void accept_item(t_fir_item it);
            int n_before;
            if (it.cmd == CMD_COEF) begin
                // writes past the last tap are dropped
                if (it.tap_index < TAPS) begin
                    tap_re[it.tap_index] = it.coef_re;
                    tap_im[it.tap_index] = it.coef_im;
                end
                return;
            end
            // first sample of a block fills the lead-in
            if (!in_block) begin
                for (int i = 0; i < TAPS; i++) begin
                    line_re[i] = it.sample_re;
                    line_im[i] = it.sample_im;
                end
                lead_count = '0;
                in_block   = 1'b1;
            end
            n_before = filtered_q.size();
            shift_in(it.sample_re, it.sample_im);
            // last sample is replicated to flush the tail
            if (it.block_end) begin
                for (int i = 0; i < LAG; i++)
                    shift_in(it.sample_re, it.sample_im);
                if (filtered_q.size() > n_before)
                    filtered_q[filtered_q.size() - 1].is_last = 1'b1;
                lead_count = '0;
                in_block   = 1'b0;
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch: %s", msg);
        endtask

        task compare_output(t_fir_out got);
            t_fir_out want;
            n_seen++;
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf("output %0d (re %0d im %0d last %0b) with none expected",
                                          n_seen, got.re, got.im, got.is_last));
                return;
            end
            want = filtered_q.pop_front();
            if (got.re !== want.re)
                report_mismatch($sformatf("output %0d: re %0d, expected %0d",
                                          n_seen, got.re, want.re));
            if (got.im !== want.im)
                report_mismatch($sformatf("output %0d: im %0d, expected %0d",
                                          n_seen, got.im, want.im));
            if (got.is_last !== want.is_last)
                report_mismatch($sformatf("output %0d: last %0b, expected %0b",
                                          n_seen, got.is_last, want.is_last));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    cfe_in_if  #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) in_if ();
    cfe_out_if #(.SAMPLE_BITS(SAMPLE_BITS))                        out_if ();

    complex_fir_edge_replicate #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_result_board sb = new();

    int src_idle_pct   = 0;
    int snk_stall_pct  = 0;
    bit pressure_armed = 1'b0;

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Output side: check each transfer, stall at random, one long hold-off on request
    initial begin
        int       hold_left;
        t_fir_out got;
        hold_left    = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.re      = out_if.out_re;
                got.im      = out_if.out_im;
                got.is_last = out_if.out_last;
                sb.compare_output(got);
                if (pressure_armed) begin
                    hold_left      = HOLD_CYCLES;
                    pressure_armed = 1'b0;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Unused fields carry random values so every bit toggles
    function automatic t_fir_item coef_item(logic [TAP_IDX_W-1:0] idx, t_coef re, t_coef im);
        t_fir_item it;
        it.cmd       = CMD_COEF;
        it.tap_index = idx;
        it.coef_re   = re;
        it.coef_im   = im;
        it.sample_re = pick_value();
        it.sample_im = pick_value();
        it.block_end = 1'($urandom);
        return it;
    endfunction

    function automatic t_fir_item sample_item(t_sample re, t_sample im, logic last);
        t_fir_item it;
        it.cmd       = CMD_SAMPLE;
        it.tap_index = TAP_IDX_W'($urandom);
        it.coef_re   = pick_value();
        it.coef_im   = pick_value();
        it.sample_re = re;
        it.sample_im = im;
        it.block_end = last;
        return it;
    endfunction

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input t_fir_item it);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.cmd       <= it.cmd;
        in_if.tap_index <= it.tap_index;
        in_if.coef_re   <= it.coef_re;
        in_if.coef_im   <= it.coef_im;
        in_if.sample_re <= it.sample_re;
        in_if.sample_im <= it.sample_im;
        in_if.block_end <= it.block_end;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        sb.accept_item(it);
    endtask

    task automatic load_taps(input t_tap_kind kind);
        t_coef cr;
        t_coef ci;
        for (int k = 0; k < TAPS; k++) begin
            case (kind)
                TAPS_EXTREME: begin
                    cr = 16'sh7fff;
                    ci = 16'sh8000;
                end
                default: begin
                    cr = pick_value() >>> 3;
                    ci = pick_value() >>> 3;
                end
            endcase
            send_item(coef_item(TAP_IDX_W'(k), cr, ci));
        end
    endtask

    // Blocks of random length, mostly short, with stray tap writes in between
    task automatic random_traffic(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(6) == 0) ? $urandom_range(16, 22) : $urandom_range(1, 6);
            for (int s = 0; s < len; s++) begin
                if ($urandom_range(9) == 0) begin
                    send_item(coef_item(TAP_IDX_W'($urandom),
                                        pick_value() >>> $urandom_range(4),
                                        pick_value() >>> $urandom_range(4)));
                    sent++;
                end
                send_item(sample_item(pick_value(), pick_value(), s == len - 1));
                sent++;
            end
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.cmd       <= CMD_COEF;
        in_if.tap_index <= '0;
        in_if.coef_re   <= '0;
        in_if.coef_im   <= '0;
        in_if.sample_re <= '0;
        in_if.sample_im <= '0;
        in_if.block_end <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full-scale taps drive both saturation limits
        load_taps(TAPS_EXTREME);
        send_item(coef_item(5'd31, 16'sh8000, 16'sh7fff));
        send_item(sample_item(16'sh7fff, 16'sh7fff, 1'b1));
        send_item(sample_item(16'sh8000, 16'sh8000, 1'b0));
        send_item(sample_item(16'sh8000, 16'sh8000, 1'b1));
        // tap write in the middle of an open block
        send_item(sample_item(16'sh0000, 16'sh0000, 1'b0));
        send_item(coef_item(5'd0, 16'sh0000, 16'sh0000));
        send_item(sample_item(16'sh7fff, 16'sh8000, 1'b1));
        load_taps(TAPS_COMPLEX);

        // Random traffic under each idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 85; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 85; end
                default: begin src_idle_pct = 32; snk_stall_pct = 32; end
            endcase
            random_traffic(5);
        end

        // Long receiver hold-off while a long block keeps the input busy
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        pressure_armed = 1'b1;
        for (int s = 0; s < 20; s++)
            send_item(sample_item(pick_value(), pick_value(), s == 19));
        in_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
